/* sv/hppc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hppc_pkg
// Types and constants shared by the holonomic pose PID controller modules.
// ----------------------------------------------------------------------------
package hppc_pkg;

	localparam int REG_W = 18;
	localparam int IDX_W = 3;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_KP_FWD         = 3'd0;
	localparam logic [IDX_W-1:0] REG_KP_SIDE        = 3'd1;
	localparam logic [IDX_W-1:0] REG_KP_TURN        = 3'd2;
	localparam logic [IDX_W-1:0] REG_KI_SHARED      = 3'd3;
	localparam logic [IDX_W-1:0] REG_KD_FWD_TURN    = 3'd4;
	localparam logic [IDX_W-1:0] REG_KD_SIDE        = 3'd5;
	localparam logic [IDX_W-1:0] REG_LIMIT_FWD_TURN = 3'd6;
	localparam logic [IDX_W-1:0] REG_LIMIT_SIDE     = 3'd7;

	// reset values of the registers
	localparam logic [REG_W-1:0] RST_KP_FWD         = 18'd32768;
	localparam logic [REG_W-1:0] RST_KP_SIDE        = 18'd19661;
	localparam logic [REG_W-1:0] RST_KP_TURN        = 18'd39322;
	localparam logic [REG_W-1:0] RST_KI_SHARED      = 18'd655;
	localparam logic [REG_W-1:0] RST_KD_FWD_TURN    = 18'd6554;
	localparam logic [REG_W-1:0] RST_KD_SIDE        = 18'd3277;
	localparam logic [REG_W-1:0] RST_LIMIT_FWD_TURN = 18'd65536;
	localparam logic [REG_W-1:0] RST_LIMIT_SIDE     = 18'd32768;

	// item kinds
	localparam logic FUNC_GOAL = 1'b0;
	localparam logic FUNC_ODOM = 1'b1;

	// loop indexes
	localparam logic [1:0] LOOP_X   = 2'd0;
	localparam logic [1:0] LOOP_Y   = 2'd1;
	localparam logic [1:0] LOOP_YAW = 2'd2;

	// angle constants in Q32 radians, cordic prescale in Q30
	localparam longint PI_Q32      = 64'sd13493037705;
	localparam longint HALF_PI_Q32 = 64'sd6746518852;
	localparam longint GAIN_Q30    = 64'sd652032874;

	localparam int MAX_STEPS = 24;
	localparam int STEP_W    = 5;

	localparam logic [31:0] ATAN_Q32 [MAX_STEPS] = '{
		32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
		32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
		32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
		32'd1048576,    32'd524288,     32'd262144,     32'd131072,
		32'd65536,      32'd32768,      32'd16384,      32'd8192,
		32'd4096,       32'd2048,       32'd1024,       32'd512
	};

	typedef struct packed {
		logic [REG_W-1:0] kp_fwd;
		logic [REG_W-1:0] kp_side;
		logic [REG_W-1:0] kp_turn;
		logic [REG_W-1:0] ki_shared;
		logic [REG_W-1:0] kd_fwd_turn;
		logic [REG_W-1:0] kd_side;
		logic [REG_W-1:0] limit_fwd_turn;
		logic [REG_W-1:0] limit_side;
	} gains_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRAP,
		ST_P_DT,
		ST_P_KP,
		ST_P_KI,
		ST_P_KD,
		ST_P_FIN,
		ST_P_OUT,
		ST_SQX,
		ST_SQY,
		ST_C_INIT,
		ST_C_MY,
		ST_C_CY,
		ST_C_ROT,
		ST_C_DONE
	} state_t;

	typedef enum logic [2:0] {
		MUL_DT,
		MUL_KP,
		MUL_KI,
		MUL_KD,
		MUL_GX,
		MUL_GY,
		MUL_SQX,
		MUL_SQY
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_INTEG,
		ACC_LOAD,
		ACC_ADD,
		ACC_ADD10,
		ACC_CX,
		ACC_CY
	} acc_op_t;

	typedef struct packed {
		logic              store_goal;
		logic              load_err;
		logic              wrap;
		logic              pid_commit;
		logic              theta_init;
		logic              rot;
		logic              load_out;
		mul_sel_t          mul_sel;
		acc_op_t           acc_op;
		logic [1:0]        loop;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic armed;
		logic wrap_ok;
		logic out_full;
		logic done;
	} stat_t;

endpackage
`default_nettype wire

/* sv/hppc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hppc_ctrl
// Sequencer: walks the wrap, three pid loops, tolerance check and cordic.
// ----------------------------------------------------------------------------
module hppc_ctrl #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            func,
	input  wire hppc_pkg::stat_t st,
	output hppc_pkg::cmd_t       cmd
);

	localparam int STEPS = (CORDIC_STEPS < hppc_pkg::MAX_STEPS) ?
		CORDIC_STEPS : hppc_pkg::MAX_STEPS;
	localparam logic [hppc_pkg::STEP_W-1:0] STEP_LAST = hppc_pkg::STEP_W'(STEPS - 1);

	hppc_pkg::state_t state_q, state_d;
	logic [1:0] loop_q;
	logic [hppc_pkg::STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hppc_pkg::ST_IDLE;
			loop_q  <= hppc_pkg::LOOP_X;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == hppc_pkg::ST_WRAP) begin
				loop_q <= hppc_pkg::LOOP_X;
			end else if (state_q == hppc_pkg::ST_P_OUT) begin
				loop_q <= loop_q + 2'd1;
			end
			if (state_q == hppc_pkg::ST_C_CY) begin
				step_q <= '0;
			end else if (state_q == hppc_pkg::ST_C_ROT) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hppc_pkg::ST_IDLE: begin
				if (in_valid && func == hppc_pkg::FUNC_ODOM && st.armed) begin
					state_d = hppc_pkg::ST_WRAP;
				end
			end
			hppc_pkg::ST_WRAP: begin
				if (st.wrap_ok) begin
					state_d = hppc_pkg::ST_P_DT;
				end
			end
			hppc_pkg::ST_P_DT:  state_d = hppc_pkg::ST_P_KP;
			hppc_pkg::ST_P_KP:  state_d = hppc_pkg::ST_P_KI;
			hppc_pkg::ST_P_KI:  state_d = hppc_pkg::ST_P_KD;
			hppc_pkg::ST_P_KD:  state_d = hppc_pkg::ST_P_FIN;
			hppc_pkg::ST_P_FIN: state_d = hppc_pkg::ST_P_OUT;
			hppc_pkg::ST_P_OUT: begin
				state_d = (loop_q == hppc_pkg::LOOP_YAW) ? hppc_pkg::ST_SQX : hppc_pkg::ST_P_DT;
			end
			hppc_pkg::ST_SQX:    state_d = hppc_pkg::ST_SQY;
			hppc_pkg::ST_SQY:    state_d = hppc_pkg::ST_C_INIT;
			hppc_pkg::ST_C_INIT: state_d = hppc_pkg::ST_C_MY;
			hppc_pkg::ST_C_MY:   state_d = hppc_pkg::ST_C_CY;
			hppc_pkg::ST_C_CY:   state_d = hppc_pkg::ST_C_ROT;
			hppc_pkg::ST_C_ROT: begin
				if (step_q == STEP_LAST) begin
					state_d = hppc_pkg::ST_C_DONE;
				end
			end
			hppc_pkg::ST_C_DONE: begin
				if (!st.out_full) begin
					state_d = hppc_pkg::ST_IDLE;
				end
			end
			default: state_d = hppc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.mul_sel    = hppc_pkg::MUL_DT;
		cmd.acc_op     = hppc_pkg::ACC_NONE;
		cmd.loop       = loop_q;
		cmd.step       = step_q;
		unique case (state_q)
			hppc_pkg::ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.store_goal = in_valid && func == hppc_pkg::FUNC_GOAL;
				cmd.load_err   = in_valid && func == hppc_pkg::FUNC_ODOM && st.armed;
			end
			hppc_pkg::ST_WRAP:  cmd.wrap = 1'b1;
			hppc_pkg::ST_P_DT:  cmd.mul_sel = hppc_pkg::MUL_DT;
			hppc_pkg::ST_P_KP: begin
				cmd.mul_sel = hppc_pkg::MUL_KP;
				cmd.acc_op  = hppc_pkg::ACC_INTEG;
			end
			hppc_pkg::ST_P_KI: begin
				cmd.mul_sel = hppc_pkg::MUL_KI;
				cmd.acc_op  = hppc_pkg::ACC_LOAD;
			end
			hppc_pkg::ST_P_KD: begin
				cmd.mul_sel = hppc_pkg::MUL_KD;
				cmd.acc_op  = hppc_pkg::ACC_ADD;
			end
			hppc_pkg::ST_P_FIN: cmd.acc_op = hppc_pkg::ACC_ADD10;
			hppc_pkg::ST_P_OUT: cmd.pid_commit = 1'b1;
			hppc_pkg::ST_SQX:   cmd.mul_sel = hppc_pkg::MUL_SQX;
			hppc_pkg::ST_SQY: begin
				cmd.mul_sel = hppc_pkg::MUL_SQY;
				cmd.acc_op  = hppc_pkg::ACC_LOAD;
			end
			hppc_pkg::ST_C_INIT: begin
				cmd.mul_sel    = hppc_pkg::MUL_GX;
				cmd.acc_op     = hppc_pkg::ACC_ADD;
				cmd.theta_init = 1'b1;
			end
			hppc_pkg::ST_C_MY: begin
				cmd.mul_sel = hppc_pkg::MUL_GY;
				cmd.acc_op  = hppc_pkg::ACC_CX;
			end
			hppc_pkg::ST_C_CY:   cmd.acc_op = hppc_pkg::ACC_CY;
			hppc_pkg::ST_C_ROT:  cmd.rot = 1'b1;
			hppc_pkg::ST_C_DONE: cmd.load_out = !st.out_full;
			default: in_ready = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

/* sv/hppc_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hppc_dp
// Datapath: pose state, shared multiplier, accumulator, cordic, result register.
// ----------------------------------------------------------------------------
module hppc_dp #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire hppc_pkg::cmd_t      cmd,
	output hppc_pkg::stat_t          st,
	input  wire hppc_pkg::gains_t    gains,
	input  wire logic signed [31:0]  pos_x,
	input  wire logic signed [31:0]  pos_y,
	input  wire logic signed [18:0]  heading,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output logic signed [20:0]       vel_x,
	output logic signed [20:0]       vel_y,
	output logic signed [19:0]       turn_rate,
	output logic                     reached
);

	localparam longint DT_Q     = ((64'sd1 <<< FRAC_BITS) + 5) / 10;
	localparam longint POS_TOL  = ((64'sd5 <<< FRAC_BITS) + 50) / 100;
	localparam longint YAW_TOL  = ((64'sd2 <<< FRAC_BITS) + 50) / 100;
	localparam longint POS_SQ   = POS_TOL * POS_TOL;
	localparam longint PI_L     =
		(hppc_pkg::PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
	localparam logic signed [31:0] PI_Q   = 32'(PI_L);
	localparam logic signed [31:0] TWO_PI = 32'(2 * PI_L);
	localparam logic signed [31:0] POS_T  = 32'(POS_TOL);
	localparam logic signed [31:0] YAW_T  = 32'(YAW_TOL);
	localparam logic signed [22:0] DT_B   = 23'(DT_Q);
	localparam logic signed [63:0] HALF_F = 64'sd1 <<< (FRAC_BITS - 1);
	localparam int TW0 = 19 + 32 - FRAC_BITS + 2;
	localparam int TW  = (TW0 > 36) ? TW0 : 36;
	localparam int CW  = 52;
	localparam logic signed [TW-1:0] PI_T   = TW'(hppc_pkg::PI_Q32);
	localparam logic signed [TW-1:0] HPI_T  = TW'(hppc_pkg::HALF_PI_Q32);
	localparam logic signed [32:0]   GAIN_A = 33'(hppc_pkg::GAIN_Q30);
	localparam logic signed [CW-1:0] HALF30 = CW'(64'sd1 <<< 29);
	localparam logic signed [CW-1:0] VMAX   = CW'(64'sd524287);
	localparam logic signed [CW-1:0] VMIN   = -CW'(64'sd524288);

	function automatic logic signed [31:0] sat32(input logic signed [57:0] v);
		if (v > 58'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -58'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [20:0] sat21(input logic signed [CW-1:0] v);
		if (v > VMAX) begin
			return 21'sh0ffff << 3 | 21'sh7;
		end else if (v < VMIN) begin
			return 21'sh100000;
		end
		return v[20:0];
	endfunction

	// pose and loop state
	logic signed [31:0] tgt_x_q, tgt_y_q;
	logic signed [18:0] tgt_h_q;
	logic               armed_q;
	logic signed [31:0] integ_sum_q [3];
	logic signed [31:0] last_err_q [3];

	// working registers
	logic signed [31:0] err_q [3];
	logic signed [31:0] integ_q;
	logic signed [63:0] acc_q;
	logic signed [55:0] prod_s1;
	logic signed [18:0] lout_q [3];
	logic signed [TW-1:0] theta_q;
	logic signed [CW-1:0] cx_q, cy_q;

	logic signed [20:0] vel_x_q, vel_y_q;
	logic signed [19:0] turn_q;
	logic               reached_q, out_valid_q;

	// loop selection
	logic signed [31:0] e_sel, old_sel, last_sel;
	logic [17:0] kp_sel, kd_sel, lim_sel;

	always_comb begin
		unique case (cmd.loop)
			hppc_pkg::LOOP_X: begin
				e_sel = err_q[0]; old_sel = integ_sum_q[0]; last_sel = last_err_q[0];
				kp_sel = gains.kp_fwd; kd_sel = gains.kd_fwd_turn;
				lim_sel = gains.limit_fwd_turn;
			end
			hppc_pkg::LOOP_Y: begin
				e_sel = err_q[1]; old_sel = integ_sum_q[1]; last_sel = last_err_q[1];
				kp_sel = gains.kp_side; kd_sel = gains.kd_side;
				lim_sel = gains.limit_side;
			end
			default: begin
				e_sel = err_q[2]; old_sel = integ_sum_q[2]; last_sel = last_err_q[2];
				kp_sel = gains.kp_turn; kd_sel = gains.kd_fwd_turn;
				lim_sel = gains.limit_fwd_turn;
			end
		endcase
	end

	// rotation angle is minus the yaw output, folded into +-pi/2
	logic signed [TW-1:0] th0, th_adj;
	logic                 flip;
	always_comb begin
		th0    = -(TW'(lout_q[2]) <<< (32 - FRAC_BITS));
		flip   = 1'b0;
		th_adj = th0;
		if (th0 > HPI_T) begin
			th_adj = th0 - PI_T;
			flip   = 1'b1;
		end else if (th0 < -HPI_T) begin
			th_adj = th0 + PI_T;
			flip   = 1'b1;
		end
	end

	logic signed [19:0] lx_adj, ly_adj;
	assign lx_adj = flip ? -20'(lout_q[0]) : 20'(lout_q[0]);
	assign ly_adj = flip ? -20'(lout_q[1]) : 20'(lout_q[1]);

	// shared multiplier operands
	logic signed [32:0] mul_a;
	logic signed [22:0] mul_b;
	always_comb begin
		unique case (cmd.mul_sel)
			hppc_pkg::MUL_DT: begin mul_a = 33'(e_sel); mul_b = DT_B; end
			hppc_pkg::MUL_KP: begin mul_a = 33'(e_sel); mul_b = 23'({1'b0, kp_sel}); end
			hppc_pkg::MUL_KI: begin
				mul_a = 33'(integ_q); mul_b = 23'({1'b0, gains.ki_shared});
			end
			hppc_pkg::MUL_KD: begin
				mul_a = 33'(e_sel) - 33'(last_sel); mul_b = 23'({1'b0, kd_sel});
			end
			hppc_pkg::MUL_GX:  begin mul_a = GAIN_A; mul_b = 23'(lx_adj); end
			hppc_pkg::MUL_GY:  begin mul_a = GAIN_A; mul_b = 23'(ly_adj); end
			hppc_pkg::MUL_SQX: begin mul_a = 33'(err_q[0]); mul_b = err_q[0][22:0]; end
			hppc_pkg::MUL_SQY: begin mul_a = 33'(err_q[1]); mul_b = err_q[1][22:0]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	logic signed [63:0] prod_ext, pid_out;
	logic signed [57:0] integ_new;
	logic signed [63:0] lim_pos;
	assign prod_ext  = 64'(prod_s1);
	assign integ_new = 58'(old_sel) + 58'((prod_ext + HALF_F) >>> FRAC_BITS);
	assign pid_out   = (acc_q + HALF_F) >>> FRAC_BITS;
	assign lim_pos   = 64'({1'b0, lim_sel});

	// wrap check
	logic wrap_ok;
	assign wrap_ok = err_q[2] <= PI_Q && err_q[2] >= -PI_Q;

	// cordic micro-rotation
	logic signed [CW-1:0] xs, ys;
	logic signed [TW-1:0] atan_t;
	assign xs     = cx_q >>> cmd.step;
	assign ys     = cy_q >>> cmd.step;
	assign atan_t = TW'({1'b0, hppc_pkg::ATAN_Q32[cmd.step]});

	// goal tolerance
	logic done;
	assign done = err_q[0] > -POS_T && err_q[0] < POS_T
		&& err_q[1] > -POS_T && err_q[1] < POS_T
		&& acc_q < 64'(POS_SQ)
		&& err_q[2] > -YAW_T && err_q[2] < YAW_T;

	logic signed [32:0] dx, dy;
	logic signed [19:0] dh;
	assign dx = 33'(tgt_x_q) - 33'(pos_x);
	assign dy = 33'(tgt_y_q) - 33'(pos_y);
	assign dh = 20'(tgt_h_q) - 20'(heading);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_x_q     <= '0;
			tgt_y_q     <= '0;
			tgt_h_q     <= '0;
			armed_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				integ_sum_q[i] <= '0;
				last_err_q[i]  <= '0;
			end
		end else begin
			if (cmd.store_goal) begin
				tgt_x_q <= pos_x;
				tgt_y_q <= pos_y;
				tgt_h_q <= heading;
				armed_q <= 1'b1;
			end
			if (cmd.pid_commit) begin
				last_err_q[cmd.loop] <= e_sel;
				if (pid_out <= lim_pos && pid_out >= -lim_pos) begin
					integ_sum_q[cmd.loop] <= integ_q;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
				if (done) begin
					armed_q <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_err) begin
			err_q[0] <= sat32(58'(dx));
			err_q[1] <= sat32(58'(dy));
			err_q[2] <= 32'(dh);
		end else if (cmd.wrap) begin
			if (err_q[2] > PI_Q) begin
				err_q[2] <= err_q[2] - TWO_PI;
			end else if (err_q[2] < -PI_Q) begin
				err_q[2] <= err_q[2] + TWO_PI;
			end
		end
		unique case (cmd.acc_op)
			hppc_pkg::ACC_INTEG: integ_q <= sat32(integ_new);
			hppc_pkg::ACC_LOAD:  acc_q <= prod_ext;
			hppc_pkg::ACC_ADD:   acc_q <= acc_q + prod_ext;
			hppc_pkg::ACC_ADD10: acc_q <= acc_q + (prod_ext <<< 3) + (prod_ext <<< 1);
			hppc_pkg::ACC_CX:    cx_q <= prod_s1[CW-1:0];
			hppc_pkg::ACC_CY:    cy_q <= prod_s1[CW-1:0];
			default: ;
		endcase
		if (cmd.pid_commit) begin
			if (pid_out > lim_pos) begin
				lout_q[cmd.loop] <= 19'(lim_pos);
			end else if (pid_out < -lim_pos) begin
				lout_q[cmd.loop] <= 19'(-lim_pos);
			end else begin
				lout_q[cmd.loop] <= pid_out[18:0];
			end
		end
		if (cmd.theta_init) begin
			theta_q <= th_adj;
		end else if (cmd.rot) begin
			if (theta_q >= 0) begin
				cx_q    <= cx_q - ys;
				cy_q    <= cy_q + xs;
				theta_q <= theta_q - atan_t;
			end else begin
				cx_q    <= cx_q + ys;
				cy_q    <= cy_q - xs;
				theta_q <= theta_q + atan_t;
			end
		end
		if (cmd.load_out) begin
			vel_x_q   <= sat21((cx_q + HALF30) >>> 30);
			vel_y_q   <= sat21((cy_q + HALF30) >>> 30);
			turn_q    <= 20'(lout_q[2]);
			reached_q <= done;
		end
	end

	assign st.armed    = armed_q;
	assign st.wrap_ok  = wrap_ok;
	assign st.out_full = out_valid_q && !out_ready;
	assign st.done     = done;

	assign out_valid = out_valid_q;
	assign vel_x     = vel_x_q;
	assign vel_y     = vel_y_q;
	assign turn_rate = turn_q;
	assign reached   = reached_q;

endmodule
`default_nettype wire

/* sv/holonomic_pose_pid_controller_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// holonomic_pose_pid_controller_top
// Pose PID controller with clamping anti-windup and cordic output rotation.
// ----------------------------------------------------------------------------
// A goal item (func 0) arms the controller. An odometry item while armed
// has its yaw error wrapped by 2*pi steps (0 or 1 of them at FRAC_BITS 16),
// then runs the x, y and yaw loops one after another on a single shared
// multiplier (dt, kp, ki, kd, sum and output states each), then a tolerance
// check, cordic setup and CORDIC_STEPS rotation steps (capped at MAX_STEPS).
// A finished result sits in an output register, so the next item is taken
// while it waits; processing stalls only when a new result is ready and the
// old one has not been taken. Odometry while disarmed is consumed with no
// result.
module holonomic_pose_pid_controller_top #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write channel
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [17:0]        cfg_data,
	// input items
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               func,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [18:0] heading,
	// result items
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [20:0]      vel_x,
	output logic signed [20:0]      vel_y,
	output logic signed [19:0]      turn_rate,
	output logic                    reached
);

	hppc_pkg::gains_t gains_q;
	hppc_pkg::cmd_t   cmd;
	hppc_pkg::stat_t  st;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.kp_fwd         <= hppc_pkg::RST_KP_FWD;
			gains_q.kp_side        <= hppc_pkg::RST_KP_SIDE;
			gains_q.kp_turn        <= hppc_pkg::RST_KP_TURN;
			gains_q.ki_shared      <= hppc_pkg::RST_KI_SHARED;
			gains_q.kd_fwd_turn    <= hppc_pkg::RST_KD_FWD_TURN;
			gains_q.kd_side        <= hppc_pkg::RST_KD_SIDE;
			gains_q.limit_fwd_turn <= hppc_pkg::RST_LIMIT_FWD_TURN;
			gains_q.limit_side     <= hppc_pkg::RST_LIMIT_SIDE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hppc_pkg::REG_KP_FWD:         gains_q.kp_fwd         <= cfg_data;
				hppc_pkg::REG_KP_SIDE:        gains_q.kp_side        <= cfg_data;
				hppc_pkg::REG_KP_TURN:        gains_q.kp_turn        <= cfg_data;
				hppc_pkg::REG_KI_SHARED:      gains_q.ki_shared      <= cfg_data;
				hppc_pkg::REG_KD_FWD_TURN:    gains_q.kd_fwd_turn    <= cfg_data;
				hppc_pkg::REG_KD_SIDE:        gains_q.kd_side        <= cfg_data;
				hppc_pkg::REG_LIMIT_FWD_TURN: gains_q.limit_fwd_turn <= cfg_data;
				hppc_pkg::REG_LIMIT_SIDE:     gains_q.limit_side     <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	hppc_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func    (func),
		.st      (st),
		.cmd     (cmd)
	);

	// arithmetic and state
	hppc_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.gains    (gains_q),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.heading  (heading),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.vel_x    (vel_x),
		.vel_y    (vel_y),
		.turn_rate(turn_rate),
		.reached  (reached)
	);

	logic signed [19:0] lim_ft;
	assign lim_ft = 20'({1'b0, gains_q.limit_fwd_turn});

	// a goal transfer arms the controller
	a_goal_arms: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == hppc_pkg::FUNC_GOAL |=> st.armed)
		else $error("goal transfer did not arm");

	// a result with reached set disarms
	a_reached_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && st.done |=> !st.armed)
		else $error("reached result left controller armed");

	// yaw output never exceeds its clamp
	a_turn_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (turn_rate <= lim_ft && turn_rate >= -lim_ft))
		else $error("turn rate beyond limit");

	// no new result is loaded over one not yet taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid && !out_ready))
		else $error("result register overwritten");

endmodule
`default_nettype wire
